@@ rtl/mcts_pkg.sv @@
// Shared types and constants for the Markov-chain trajectory sampler.
// Holds item codes, field widths, the command and config structs.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mcts_pkg;

   // Field widths of the request and response items
   localparam int TRAJ_W   = 8;
   localparam int STATE_W  = 6;
   localparam int BRANCH_W = 3;
   localparam int CDF_W    = 17;
   localparam int VEL_W    = 24;
   localparam int RND_W    = 16;
   localparam int SUM_W    = 40;
   localparam int BCNT_W   = 4;   // branches_in_use register
   localparam int BR_NUM_W = 7;   // enough for a branch count up to 64

   // Stream bus widths
   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 56;

   // Control register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRANCHES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START    = 1'd1;
   localparam logic [BCNT_W-1:0]      BRANCHES_RESET = 4'd8;
   localparam logic [STATE_W-1:0]     START_RESET    = 6'd0;

   // Saturation limits of the displacement sum
   localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request kinds carried in tuser
   typedef enum logic [REQ_TUSER_W-1:0] {
      MODE_LOAD_BRANCH = 2'd0,
      MODE_LOAD_VEL    = 2'd1,
      MODE_START       = 2'd2,
      MODE_STEP        = 2'd3
   } mode_type;

   // Classified request handed from front to back
   typedef struct packed {
      mode_type                  mode;
      logic [TRAJ_W-1:0]         traj;
      logic [STATE_W-1:0]        state;
      logic [BRANCH_W-1:0]       branch;
      logic [CDF_W-1:0]          cdf;
      logic [STATE_W-1:0]        target;
      logic signed [VEL_W-1:0]   vel;
      logic [RND_W-1:0]          rnd;
   } cmd_type;

   // Control register contents
   typedef struct packed {
      logic [BCNT_W-1:0]  branches;
      logic [STATE_W-1:0] start_state;
   } cfg_type;

   // Address width for a memory of the given depth
   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

@@ rtl/markov_chain_trajectory_sampler_top.sv @@
// Markov-chain trajectory sampler, top level: stream ports, control registers,
// front end, command queue and back end. Depends on mcts_pkg, mcts_front,
// mcts_queue and mcts_back.
`timescale 1ns / 1ps

// Load-branch, load-velocity and start requests are executed as they are popped;
// a step request runs through trajectory read, branch bank read,
// velocity read, saturating sum update and response handoff, set by the chain of
// three dependent registered memory reads. A two-entry queue lets the request
// side keep accepting while a step is in progress, and the response register
// holds a finished result while the next request is taken. Branch entries sit in
// one bank per branch slot so all slots of a state are compared in the same cycle.
// Tables and trajectories hold no defined value until loaded or started.
// Requests with an out-of-range index are taken and dropped without a response.

module markov_chain_trajectory_sampler_top #(
   parameter int MAX_BRANCHES = 8,
   parameter int NUM_STATES   = 64,
   parameter int NUM_TRAJS    = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // traj_index[7:0], state_index[13:8], branch_index[16:14], cdf_value[33:17],
   // target_state[39:34], velocity_value[63:40], random_value[79:64]
   input  logic [mcts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // mode[1:0]
   input  logic [mcts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // Response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_traj[7:0], new_state[13:8], displacement[53:14], moved[54], zero[55]
   output logic [mcts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Control register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mcts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mcts_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [mcts_pkg::BCNT_W-1:0]   branches_ff, branches_in;
   logic [mcts_pkg::STATE_W-1:0]  start_ff, start_in;
   mcts_pkg::cfg_type             cfg;
   logic                          csr_write;

   logic                          push;
   mcts_pkg::cmd_type             push_cmd;
   logic                          q_full;
   logic                          q_empty;
   logic                          q_pop;
   mcts_pkg::cmd_type             q_data;

   // Control registers, always writable
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      branches_in = branches_ff;
      start_in    = start_ff;
      if (csr_write) begin
         case (csr_index)
            mcts_pkg::CSR_BRANCHES: branches_in = csr_data[mcts_pkg::BCNT_W-1:0];
            mcts_pkg::CSR_START:    start_in    = csr_data[mcts_pkg::STATE_W-1:0];
            default: begin
               branches_in = branches_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         branches_ff <= mcts_pkg::BRANCHES_RESET;
         start_ff    <= mcts_pkg::START_RESET;
      end else begin
         branches_ff <= branches_in;
         start_ff    <= start_in;
      end
   end

   assign cfg.branches    = branches_ff;
   assign cfg.start_state = start_ff;

   // Request decode and filtering
   mcts_front #(
      .MAX_BRANCHES (MAX_BRANCHES),
      .NUM_STATES   (NUM_STATES),
      .NUM_TRAJS    (NUM_TRAJS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // Command queue
   mcts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // Execution and response
   mcts_back #(
      .MAX_BRANCHES (MAX_BRANCHES),
      .NUM_STATES   (NUM_STATES),
      .NUM_TRAJS    (NUM_TRAJS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/mcts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on mcts_pkg for the address width function.
`timescale 1ns / 1ps

module mcts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [mcts_pkg::addr_width(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [mcts_pkg::addr_width(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mcts_front.sv @@
// Front end: takes request items, decodes the kind and drops out-of-range ones.
// Surviving requests are pushed as commands into the queue. Depends on mcts_pkg.
`timescale 1ns / 1ps

module mcts_front #(
   parameter int MAX_BRANCHES = 8,
   parameter int NUM_STATES   = 64,
   parameter int NUM_TRAJS    = 256
) (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mcts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [mcts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                 queue_full,
   output logic                                 push,
   output mcts_pkg::cmd_type                    cmd
);

   logic accept;
   logic keep;

   // Unpack the request fields
   always_comb begin
      cmd.mode   = mcts_pkg::mode_type'(req_tuser);
      cmd.traj   = req_tdata[7:0];
      cmd.state  = req_tdata[13:8];
      cmd.branch = req_tdata[16:14];
      cmd.cdf    = req_tdata[33:17];
      cmd.target = req_tdata[39:34];
      cmd.vel    = req_tdata[63:40];
      cmd.rnd    = req_tdata[79:64];
   end

   // Range checks per request kind
   always_comb begin
      case (cmd.mode)
         mcts_pkg::MODE_LOAD_BRANCH: begin
            keep = (32'(cmd.state) < 32'(NUM_STATES)) &&
                   (32'(cmd.branch) < 32'(MAX_BRANCHES));
         end
         mcts_pkg::MODE_LOAD_VEL: begin
            keep = 32'(cmd.state) < 32'(NUM_STATES);
         end
         mcts_pkg::MODE_START, mcts_pkg::MODE_STEP: begin
            keep = 32'(cmd.traj) < 32'(NUM_TRAJS);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Dropped requests are still taken off the bus
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && keep;

endmodule

@@ rtl/mcts_queue.sv @@
// Short command queue between the front and back ends.
// Depends on mcts_pkg for the command type and depth.
`timescale 1ns / 1ps

module mcts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcts_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output mcts_pkg::cmd_type pop_data,
   output logic              empty
);

   localparam int PTR_W = mcts_pkg::addr_width(mcts_pkg::QUEUE_DEPTH);
   localparam int CNT_W = mcts_pkg::addr_width(mcts_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(mcts_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(mcts_pkg::QUEUE_DEPTH);

   mcts_pkg::cmd_type slot_ff [mcts_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);

endmodule

@@ rtl/mcts_back.sv @@
// Back end: executes table loads, trajectory starts and steps.
// Owns the branch banks, velocity table and trajectory memory (mcts_ram),
// and the response output register. Depends on mcts_pkg and mcts_ram.
`timescale 1ns / 1ps

module mcts_back #(
   parameter int MAX_BRANCHES = 8,
   parameter int NUM_STATES   = 64,
   parameter int NUM_TRAJS    = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mcts_pkg::cfg_type                 cfg,
   input  logic                              q_empty,
   input  mcts_pkg::cmd_type                 q_data,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mcts_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int SAW    = mcts_pkg::addr_width(NUM_STATES);
   localparam int TAW    = mcts_pkg::addr_width(NUM_TRAJS);
   localparam int BANK_W = mcts_pkg::STATE_W + mcts_pkg::CDF_W;
   localparam int TRJ_W  = mcts_pkg::SUM_W + mcts_pkg::STATE_W;
   localparam int SUM_W  = mcts_pkg::SUM_W;
   localparam int VEL_W  = mcts_pkg::VEL_W;
   localparam int ST_W   = mcts_pkg::STATE_W;
   localparam int CDF_W  = mcts_pkg::CDF_W;
   localparam int BNW    = mcts_pkg::BR_NUM_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_TRAJ   = 5'b00010,
      ST_BRANCH = 5'b00100,
      ST_VEL    = 5'b01000,
      ST_OUT    = 5'b10000
   } back_state_type;

   back_state_type                    state_ff, state_in;
   logic [mcts_pkg::TRAJ_W-1:0]       traj_ff, traj_in;
   logic [mcts_pkg::RND_W-1:0]        rnd_ff, rnd_in;
   logic [ST_W-1:0]                   cur_ff, cur_in;
   logic                              cur_ok_ff, cur_ok_in;
   logic signed [SUM_W-1:0]           sum_ff, sum_in;
   logic                              moved_ff, moved_in;
   logic                              tgt_ok_ff, tgt_ok_in;
   logic [ST_W-1:0]                   res_state_ff, res_state_in;
   logic signed [SUM_W-1:0]           res_sum_ff, res_sum_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mcts_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [BANK_W-1:0]        bank_rd [MAX_BRANCHES];
   logic [TRJ_W-1:0]         traj_rd;
   logic signed [VEL_W-1:0]  vel_rd;
   logic                     traj_we;
   logic [TAW-1:0]           traj_wr_addr;
   logic [TRJ_W-1:0]         traj_wr_data;
   logic                     out_free;
   logic                     out_load;
   logic [BNW-1:0]           nb;
   logic                     hit;
   logic [ST_W-1:0]          sel_tgt;
   logic signed [VEL_W-1:0]  vel_add;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_sat;
   logic                     do_start;

   // Pop one command whenever idle
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign do_start = q_pop && (q_data.mode == mcts_pkg::MODE_START);

   // One bank per branch slot: {target, cdf} indexed by state
   for (genvar b = 0; b < MAX_BRANCHES; b++) begin : g_bank
      mcts_ram #(
         .WIDTH (BANK_W),
         .DEPTH (NUM_STATES)
      ) u_bank (
         .clock   (clock),
         .wr_en   (q_pop && (q_data.mode == mcts_pkg::MODE_LOAD_BRANCH) &&
                   (32'(q_data.branch) == 32'(b))),
         .wr_addr (SAW'(q_data.state)),
         .wr_data ({q_data.target, q_data.cdf}),
         .rd_addr (SAW'(traj_rd[ST_W-1:0])),
         .rd_data (bank_rd[b])
      );
   end

   // Velocity per state, read at the chosen target
   mcts_ram #(
      .WIDTH (VEL_W),
      .DEPTH (NUM_STATES)
   ) u_vel (
      .clock   (clock),
      .wr_en   (q_pop && (q_data.mode == mcts_pkg::MODE_LOAD_VEL)),
      .wr_addr (SAW'(q_data.state)),
      .wr_data (q_data.vel),
      .rd_addr (SAW'(sel_tgt)),
      .rd_data (vel_rd)
   );

   // Trajectory memory: {sum, state}
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign out_load     = (state_ff == ST_OUT) && out_free;
   assign traj_we      = do_start || (out_load && moved_ff);
   assign traj_wr_addr = do_start ? TAW'(q_data.traj) : TAW'(traj_ff);
   assign traj_wr_data = do_start ? {SUM_W'(0), cfg.start_state}
                                  : {res_sum_ff, res_state_ff};

   mcts_ram #(
      .WIDTH (TRJ_W),
      .DEPTH (NUM_TRAJS)
   ) u_traj (
      .clock   (clock),
      .wr_en   (traj_we),
      .wr_addr (traj_wr_addr),
      .wr_data (traj_wr_data),
      .rd_addr (TAW'(q_data.traj)),
      .rd_data (traj_rd)
   );

   // Branch search: lowest examined slot whose cdf exceeds the draw
   always_comb begin
      nb = (BNW'(cfg.branches) > BNW'(MAX_BRANCHES)) ? BNW'(MAX_BRANCHES)
                                                     : BNW'(cfg.branches);
      hit     = 1'b0;
      sel_tgt = cur_ff;
      for (int k = MAX_BRANCHES - 1; k >= 0; k--) begin
         if (cur_ok_ff && (BNW'(k) < nb) &&
             ({1'b0, rnd_ff} < bank_rd[k][CDF_W-1:0])) begin
            hit     = 1'b1;
            sel_tgt = bank_rd[k][BANK_W-1:CDF_W];
         end
      end
   end

   // Saturating displacement update
   always_comb begin
      vel_add  = tgt_ok_ff ? vel_rd : '0;
      sum_wide = {sum_ff[SUM_W-1], sum_ff} +
                 {{(SUM_W + 1 - VEL_W){vel_add[VEL_W-1]}}, vel_add};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? mcts_pkg::SUM_MIN : mcts_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // Step sequencer
   always_comb begin
      state_in     = state_ff;
      traj_in      = traj_ff;
      rnd_in       = rnd_ff;
      cur_in       = cur_ff;
      cur_ok_in    = cur_ok_ff;
      sum_in       = sum_ff;
      moved_in     = moved_ff;
      tgt_ok_in    = tgt_ok_ff;
      res_state_in = res_state_ff;
      res_sum_in   = res_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && (q_data.mode == mcts_pkg::MODE_STEP)) begin
               traj_in  = q_data.traj;
               rnd_in   = q_data.rnd;
               state_in = ST_TRAJ;
            end
         end
         ST_TRAJ: begin
            cur_in    = traj_rd[ST_W-1:0];
            sum_in    = traj_rd[TRJ_W-1:ST_W];
            cur_ok_in = 32'(traj_rd[ST_W-1:0]) < 32'(NUM_STATES);
            state_in  = ST_BRANCH;
         end
         ST_BRANCH: begin
            moved_in     = hit;
            res_state_in = sel_tgt;
            tgt_ok_in    = 32'(sel_tgt) < 32'(NUM_STATES);
            state_in     = ST_VEL;
         end
         ST_VEL: begin
            res_sum_in = moved_ff ? sum_sat : sum_ff;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, moved_ff, res_sum_ff, res_state_ff, traj_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      traj_ff      <= traj_in;
      rnd_ff       <= rnd_in;
      cur_ff       <= cur_in;
      cur_ok_ff    <= cur_ok_in;
      sum_ff       <= sum_in;
      moved_ff     <= moved_in;
      tgt_ok_ff    <= tgt_ok_in;
      res_state_ff <= res_state_in;
      res_sum_ff   <= res_sum_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A fresh response only comes out of the handoff state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised outside handoff state");

   // A popped step request starts the trajectory read
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_data.mode == mcts_pkg::MODE_STEP)) |=> (state_ff == ST_TRAJ))
      else $error("step request did not start trajectory read");

   // Without a taken branch, state and sum are unchanged
   a_no_move_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && !moved_ff) |->
      ((res_sum_ff == sum_ff) && (res_state_ff == cur_ff)))
      else $error("trajectory changed without a taken branch");

endmodule
